>>> hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hdl/gsfa_pkg.sv
`timescale 1ns / 1ps

package gsfa_pkg;

   // Operation kinds
   localparam logic [2:0] KIND_NEG = 3'd0;
   localparam logic [2:0] KIND_INV = 3'd1;
   localparam logic [2:0] KIND_POW = 3'd2;
   localparam logic [2:0] KIND_ADD = 3'd3;
   localparam logic [2:0] KIND_MUL = 3'd4;

   // Status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_RANGE    = 3'd1;
   localparam logic [2:0] ST_ZERO_INV = 3'd2;
   localparam logic [2:0] ST_ORDER    = 3'd3;
   localparam logic [2:0] ST_EXP      = 3'd4;

   // Supported field orders
   localparam logic [3:0] ORD_2 = 4'd2;
   localparam logic [3:0] ORD_3 = 4'd3;
   localparam logic [3:0] ORD_4 = 4'd4;
   localparam logic [3:0] ORD_5 = 4'd5;
   localparam logic [3:0] ORD_9 = 4'd9;

   // Register index of the field order
   localparam logic REG_FIELD_ORDER = 1'b0;
   localparam logic [3:0] FIELD_ORDER_RESET = 4'd2;

   // Item after the exponent has been reduced
   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] first_operand;
      logic [3:0] second_operand;
      logic [1:0] exp_mod4;
      logic [3:0] exp_mod9;
   } reduced_type;

   // Result beat
   typedef struct packed {
      logic [2:0] status;
      logic [3:0] result;
   } answer_type;

   // Negation in GF(9), element a+3b
   function automatic logic [3:0] neg9(input logic [3:0] e);
      case (e)
         4'd0: neg9 = 4'd0;
         4'd1: neg9 = 4'd2;
         4'd2: neg9 = 4'd1;
         4'd3: neg9 = 4'd6;
         4'd4: neg9 = 4'd8;
         4'd5: neg9 = 4'd7;
         4'd6: neg9 = 4'd3;
         4'd7: neg9 = 4'd5;
         4'd8: neg9 = 4'd4;
         default: neg9 = 4'd0;
      endcase
   endfunction

   // Inverse in GF(9)
   function automatic logic [3:0] inv9(input logic [3:0] e);
      case (e)
         4'd0: inv9 = 4'd0;
         4'd1: inv9 = 4'd1;
         4'd2: inv9 = 4'd2;
         4'd3: inv9 = 4'd5;
         4'd4: inv9 = 4'd8;
         4'd5: inv9 = 4'd3;
         4'd6: inv9 = 4'd7;
         4'd7: inv9 = 4'd6;
         4'd8: inv9 = 4'd4;
         default: inv9 = 4'd0;
      endcase
   endfunction

   // Log to base X, indexed by element minus one
   function automatic logic [2:0] log9(input logic [2:0] i);
      case (i)
         3'd0: log9 = 3'd0;
         3'd1: log9 = 3'd4;
         3'd2: log9 = 3'd1;
         3'd3: log9 = 3'd2;
         3'd4: log9 = 3'd7;
         3'd5: log9 = 3'd5;
         3'd6: log9 = 3'd3;
         3'd7: log9 = 3'd6;
         default: log9 = 3'd0;
      endcase
   endfunction

   // Powers of the root X
   function automatic logic [3:0] exp9(input logic [2:0] k);
      case (k)
         3'd0: exp9 = 4'd1;
         3'd1: exp9 = 4'd3;
         3'd2: exp9 = 4'd4;
         3'd3: exp9 = 4'd7;
         3'd4: exp9 = 4'd2;
         3'd5: exp9 = 4'd6;
         3'd6: exp9 = 4'd8;
         3'd7: exp9 = 4'd5;
         default: exp9 = 4'd1;
      endcase
   endfunction

   // Low base-3 digit of an element
   function automatic logic [1:0] digit_lo(input logic [3:0] e);
      case (e)
         4'd0, 4'd3, 4'd6: digit_lo = 2'd0;
         4'd1, 4'd4, 4'd7: digit_lo = 2'd1;
         4'd2, 4'd5, 4'd8: digit_lo = 2'd2;
         default: digit_lo = 2'd0;
      endcase
   endfunction

   // High base-3 digit of an element
   function automatic logic [1:0] digit_hi(input logic [3:0] e);
      case (e)
         4'd0, 4'd1, 4'd2: digit_hi = 2'd0;
         4'd3, 4'd4, 4'd5: digit_hi = 2'd1;
         4'd6, 4'd7, 4'd8: digit_hi = 2'd2;
         default: digit_hi = 2'd0;
      endcase
   endfunction

endpackage

>>> hdl/gsfa_reduce.sv
`timescale 1ns / 1ps

// Two pipeline stages that reduce the 32-bit exponent mod 4 and mod 9.
// 64 is 1 mod 9, so 6-bit chunks are summed and then folded again.
module gsfa_reduce (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [2:0]           in_kind,
   input  logic [3:0]           in_first,
   input  logic [3:0]           in_second,
   input  logic [31:0]          in_exponent,
   output logic                 out_valid,
   input  logic                 out_ready,
   output gsfa_pkg::reduced_type out_item
);

   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic [2:0] s1_kind_ff;
   logic [3:0] s1_first_ff;
   logic [3:0] s1_second_ff;
   logic [1:0] s1_mod4_ff;
   logic [8:0] s1_sum_ff;
   logic [8:0] s1_sum_in;
   logic       s1_ready;

   logic                  s2_valid_ff;
   logic                  s2_valid_in;
   gsfa_pkg::reduced_type s2_item_ff;
   gsfa_pkg::reduced_type s2_item_in;
   logic                  s2_ready;

   logic [6:0] fold;
   logic [6:0] f36;
   logic [6:0] f18;
   logic [6:0] f9;

   // Stage handshake: a stage takes a beat when empty or draining
   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // Sum the 6-bit chunks of the exponent
   assign s1_sum_in = {3'd0, in_exponent[5:0]} + {3'd0, in_exponent[11:6]}
                    + {3'd0, in_exponent[17:12]} + {3'd0, in_exponent[23:18]}
                    + {3'd0, in_exponent[29:24]} + {7'd0, in_exponent[31:30]};
   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_kind_ff   <= in_kind;
         s1_first_ff  <= in_first;
         s1_second_ff <= in_second;
         s1_mod4_ff   <= in_exponent[1:0];
         s1_sum_ff    <= s1_sum_in;
      end
   end

   // Fold the sum below 72, then subtract 36, 18 and 9 as needed
   always_comb begin
      fold = {1'b0, s1_sum_ff[5:0]} + {4'd0, s1_sum_ff[8:6]};
      f36  = (fold >= 7'd36) ? fold - 7'd36 : fold;
      f18  = (f36 >= 7'd18) ? f36 - 7'd18 : f36;
      f9   = (f18 >= 7'd9) ? f18 - 7'd9 : f18;
      s2_item_in.kind           = s1_kind_ff;
      s2_item_in.first_operand  = s1_first_ff;
      s2_item_in.second_operand = s1_second_ff;
      s2_item_in.exp_mod4       = s1_mod4_ff;
      s2_item_in.exp_mod9       = f9[3:0];
   end

   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_item_ff <= s2_item_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_item  = s2_item_ff;

endmodule

>>> hdl/gsfa_core.sv
`timescale 1ns / 1ps

// Final stage: checks operands and evaluates the operation in the field,
// registering the result beat.
module gsfa_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [3:0]            field_order,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  gsfa_pkg::reduced_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output gsfa_pkg::answer_type  out_answer
);

   logic                 valid_ff;
   logic                 valid_in;
   gsfa_pkg::answer_type answer_ff;
   gsfa_pkg::answer_type answer_in;

   logic [3:0] q;
   logic [2:0] kind;
   logic [3:0] x;
   logic [3:0] y;
   logic       order_ok;
   logic [3:0] r_neg;
   logic [3:0] r_inv;
   logic [3:0] r_pow;
   logic [3:0] r_add;
   logic [3:0] r_mul;
   logic [4:0] sum;
   logic [4:0] prod;
   logic [4:0] prod10;
   logic [1:0] lo;
   logic [1:0] hi;
   logic [2:0] lo_sum;
   logic [2:0] hi_sum;
   logic [6:0] pow_log;
   logic [2:0] mul_log;
   logic [7:0] prod_full;

   assign q    = field_order;
   assign kind = in_item.kind;
   assign x    = in_item.first_operand;
   assign y    = in_item.second_operand;

   assign order_ok = q inside {gsfa_pkg::ORD_2, gsfa_pkg::ORD_3, gsfa_pkg::ORD_4,
                               gsfa_pkg::ORD_5, gsfa_pkg::ORD_9};

   // Negate
   always_comb begin
      if (q == gsfa_pkg::ORD_2 || q == gsfa_pkg::ORD_4) begin
         r_neg = x;
      end else if (q == gsfa_pkg::ORD_9) begin
         r_neg = gsfa_pkg::neg9(x);
      end else begin
         r_neg = (x == 4'd0) ? 4'd0 : q - x;
      end
   end

   // Invert
   always_comb begin
      if (q == gsfa_pkg::ORD_4 || q == gsfa_pkg::ORD_5) begin
         r_inv = (x == 4'd2) ? 4'd3 : (x == 4'd3) ? 4'd2 : x;
      end else if (q == gsfa_pkg::ORD_9) begin
         r_inv = gsfa_pkg::inv9(x);
      end else begin
         r_inv = x;
      end
   end

   // Power: order 4 swaps 2 and 3 for an even non-multiple-of-4 exponent
   always_comb begin
      pow_log = {4'd0, gsfa_pkg::log9(3'(x - 4'd1))} * {3'd0, in_item.exp_mod9};
      if (q == gsfa_pkg::ORD_4) begin
         if (in_item.exp_mod4 == 2'd0 || x <= 4'd1) begin
            r_pow = x;
         end else begin
            r_pow = (x == 4'd2) ? 4'd3 : 4'd2;
         end
      end else if (q == gsfa_pkg::ORD_9 && x >= 4'd3) begin
         r_pow = gsfa_pkg::exp9(pow_log[2:0]);
      end else begin
         r_pow = x;
      end
   end

   // Add: XOR, base-3 digits, or one compare and subtract
   always_comb begin
      sum    = {1'b0, x} + {1'b0, y};
      lo_sum = {1'b0, gsfa_pkg::digit_lo(x)} + {1'b0, gsfa_pkg::digit_lo(y)};
      hi_sum = {1'b0, gsfa_pkg::digit_hi(x)} + {1'b0, gsfa_pkg::digit_hi(y)};
      lo     = (lo_sum >= 3'd3) ? 2'(lo_sum - 3'd3) : lo_sum[1:0];
      hi     = (hi_sum >= 3'd3) ? 2'(hi_sum - 3'd3) : hi_sum[1:0];
      if (q == gsfa_pkg::ORD_2 || q == gsfa_pkg::ORD_4) begin
         r_add = x ^ y;
      end else if (q == gsfa_pkg::ORD_9) begin
         r_add = {2'd0, lo} + {1'b0, hi, 1'b0} + {2'd0, hi};
      end else begin
         r_add = (sum >= {1'b0, q}) ? 4'(sum - {1'b0, q}) : sum[3:0];
      end
   end

   // Multiply
   always_comb begin
      prod_full = x * y;
      prod      = prod_full[4:0];
      prod10    = (prod >= 5'd10) ? prod - 5'd10 : prod;
      mul_log   = gsfa_pkg::log9(3'(x - 4'd1)) + gsfa_pkg::log9(3'(y - 4'd1));
      if (x == 4'd0 || y == 4'd0) begin
         r_mul = 4'd0;
      end else if (x == 4'd1) begin
         r_mul = y;
      end else if (y == 4'd1) begin
         r_mul = x;
      end else if (q == gsfa_pkg::ORD_4) begin
         r_mul = (x != y) ? 4'd1 : 4'd5 - x;
      end else if (q == gsfa_pkg::ORD_9) begin
         r_mul = gsfa_pkg::exp9(mul_log);
      end else if (q == gsfa_pkg::ORD_5) begin
         r_mul = (prod10 >= 5'd5) ? 4'(prod10 - 5'd5) : prod10[3:0];
      end else begin
         r_mul = (prod >= 5'd3) ? 4'(prod - 5'd3) : prod[3:0];
      end
   end

   // Checks in priority order, then select the operation
   always_comb begin
      answer_in.status = gsfa_pkg::ST_OK;
      answer_in.result = 4'd0;
      if (!order_ok) begin
         answer_in.status = gsfa_pkg::ST_ORDER;
      end else if (!(kind inside {gsfa_pkg::KIND_NEG, gsfa_pkg::KIND_INV, gsfa_pkg::KIND_POW,
                                  gsfa_pkg::KIND_ADD, gsfa_pkg::KIND_MUL}) || x >= q) begin
         answer_in.status = gsfa_pkg::ST_RANGE;
      end else if ((kind == gsfa_pkg::KIND_ADD || kind == gsfa_pkg::KIND_MUL) && y >= q) begin
         answer_in.status = gsfa_pkg::ST_RANGE;
      end else begin
         case (kind)
            gsfa_pkg::KIND_NEG: begin
               answer_in.result = r_neg;
            end
            gsfa_pkg::KIND_INV: begin
               if (x == 4'd0) begin
                  answer_in.status = gsfa_pkg::ST_ZERO_INV;
               end else begin
                  answer_in.result = r_inv;
               end
            end
            gsfa_pkg::KIND_POW: begin
               if (q == gsfa_pkg::ORD_4 && in_item.exp_mod4[0]) begin
                  answer_in.status = gsfa_pkg::ST_EXP;
               end else begin
                  answer_in.result = r_pow;
               end
            end
            gsfa_pkg::KIND_ADD: begin
               answer_in.result = r_add;
            end
            default: begin
               answer_in.result = r_mul;
            end
         endcase
      end
   end

   // Output register: load when empty or when the beat is taken
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         answer_ff <= answer_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_answer = answer_ff;

endmodule

>>> hdl/small_galois_field_alu.sv
`timescale 1ns / 1ps

// Arithmetic unit for GF(2), GF(3), GF(4), GF(5) and GF(9), the order set by the
// field_order register at address 0 (reset 2). Each request beat carries an
// operation (negate, invert, power, add, multiply), two operands and a 32-bit
// exponent, and yields one response beat with the result and a status code; any
// nonzero status forces the result to 0. The block is a three-stage pipeline:
// the first two stages reduce the exponent mod 4 and mod 9, the third evaluates
// the operation into the output register. It accepts one beat per cycle while
// responses are taken, and a request passes through the two reduction stages and
// then the output register; a stalled response backs the pipeline up without
// losing beats. Write field_order only while no beats are in flight.
module small_galois_field_alu (
   input  logic        clock,
   input  logic        reset,
   // kind[2:0], first_operand[6:3], second_operand[10:7], exponent[42:11], zero pad
   input  logic [47:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // result[3:0], status[6:4], zero pad
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [3:0] field_order_ff;
   logic [3:0] field_order_in;
   logic       csr_write;

   logic                  mid_valid;
   logic                  mid_ready;
   gsfa_pkg::reduced_type mid_item;
   gsfa_pkg::answer_type  answer;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                    && (csr_paddr[2] == gsfa_pkg::REG_FIELD_ORDER);
   assign field_order_in = csr_write ? csr_pwdata[3:0] : field_order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_order_ff <= gsfa_pkg::FIELD_ORDER_RESET;
      end else begin
         field_order_ff <= field_order_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == gsfa_pkg::REG_FIELD_ORDER)
                     ? {28'd0, field_order_ff} : 32'd0;

   // Exponent reduction stages
   gsfa_reduce u_reduce (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_kind     (req_tdata[2:0]),
      .in_first    (req_tdata[6:3]),
      .in_second   (req_tdata[10:7]),
      .in_exponent (req_tdata[42:11]),
      .out_valid   (mid_valid),
      .out_ready   (mid_ready),
      .out_item    (mid_item)
   );

   // Field operation and output register
   gsfa_core u_core (
      .clock       (clock),
      .reset       (reset),
      .field_order (field_order_ff),
      .in_valid    (mid_valid),
      .in_ready    (mid_ready),
      .in_item     (mid_item),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_answer  (answer)
   );

   assign rsp_tdata = {1'b0, answer.status, answer.result};

endmodule

>>> hdl/gsfa_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Port-level checks on the response stream.
module gsfa_checker (
   input logic        clock,
   input logic        reset,
   input logic [47:0] req_tdata,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [2:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   // An error beat carries a zero result
   `ASSERT_CLK(a_err_zero, rsp_tvalid && (rsp_tdata[6:4] != gsfa_pkg::ST_OK) |-> rsp_tdata[3:0] == 4'd0, "error beat with nonzero result")

   // Status and result stay within their code ranges
   `ASSERT_CLK(a_codes, rsp_tvalid |-> rsp_tdata[6:4] <= gsfa_pkg::ST_EXP && rsp_tdata[3:0] <= 4'd8, "response code out of range")

   // A stalled response holds
   `ASSERT_CLK(a_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // Reset empties the pipeline
   `ASSERT_ALWAYS(a_reset, reset |=> !rsp_tvalid, "response valid after reset")

endmodule

bind small_galois_field_alu gsfa_checker u_checker (.*);
